// ===== rtl/scl_pkg.sv =====
// Shared types, constants and helper functions of the serial command line decoder.
// Used by scl_line_buf, scl_cmd_decode and serial_command_line_decoder.
// No dependencies.
`default_nettype none

package scl_pkg;

    // Line buffer geometry
    localparam int LINE_DEPTH = 10;
    localparam int COUNT_W    = $clog2(LINE_DEPTH + 1);
    localparam int VIEW_LEN   = 5;
    localparam int ARG_FIRST  = 2;
    localparam int ARG_LAST   = 4;
    localparam int NUM_DUTY   = 5;

    typedef logic [7:0] char_t;

    // Status codes reported with each result
    localparam logic [3:0] ST_NONE     = 4'd0;
    localparam logic [3:0] ST_SET_A    = 4'd1;
    localparam logic [3:0] ST_SET_B    = 4'd2;
    localparam logic [3:0] ST_SET_C    = 4'd3;
    localparam logic [3:0] ST_SET_D    = 4'd4;
    localparam logic [3:0] ST_SET_E    = 4'd5;
    localparam logic [3:0] ST_REPORT   = 4'd6;
    localparam logic [3:0] ST_LAMP_ON  = 4'd7;
    localparam logic [3:0] ST_LAMP_OFF = 4'd8;
    localparam logic [3:0] ST_CLEAR    = 4'd9;
    localparam logic [3:0] ST_FULL     = 4'd10;
    localparam logic [3:0] ST_HALF     = 4'd11;
    localparam logic [3:0] ST_WRONG    = 4'd12;

    // Wave regeneration request codes
    localparam logic [1:0] RL_NONE = 2'd0;
    localparam logic [1:0] RL_FULL = 2'd1;
    localparam logic [1:0] RL_HALF = 2'd2;

    // Characters with a special meaning
    localparam char_t CH_TAB   = 8'h09;
    localparam char_t CH_LF    = 8'h0A;
    localparam char_t CH_CR    = 8'h0D;
    localparam char_t CH_SPACE = 8'h20;
    localparam char_t CH_PLUS  = 8'h2B;
    localparam char_t CH_MINUS = 8'h2D;
    localparam char_t CH_ZERO  = 8'h30;
    localparam char_t CH_NINE  = 8'h39;

    // First positions of the line as seen after the current character is stored
    typedef struct packed {
        char_t [VIEW_LEN-1:0] chars;
        logic  [VIEW_LEN-1:0] present;
    } line_view_t;

    // Outcome of decoding one character
    typedef struct packed {
        logic       line_done;
        logic       accepted;
        logic [3:0] status;
        char_t      number;
    } cmd_result_t;

    function automatic logic is_blank(input char_t c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input char_t c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Reads positions two to four like atoi: blanks, an optional sign, digits.
    // The value wraps modulo 256, which 8-bit arithmetic gives directly.
    function automatic char_t parse_number(input line_view_t v);
        char_t acc;
        char_t c;
        logic  neg;
        logic  in_num;
        logic  stop;
        acc    = '0;
        neg    = 1'b0;
        in_num = 1'b0;
        stop   = 1'b0;
        for (int i = ARG_FIRST; i <= ARG_LAST; i++)
        begin
            c = v.chars[i];
            if (!stop)
            begin
                if (!v.present[i])
                begin
                    stop = 1'b1;
                end
                else if (!in_num)
                begin
                    if (c == CH_PLUS || c == CH_MINUS)
                    begin
                        neg    = (c == CH_MINUS);
                        in_num = 1'b1;
                    end
                    else if (is_digit(c))
                    begin
                        acc    = c - CH_ZERO;
                        in_num = 1'b1;
                    end
                    else if (!is_blank(c))
                    begin
                        stop = 1'b1;
                    end
                end
                else if (is_digit(c))
                begin
                    acc = acc * 8'd10 + (c - CH_ZERO);
                end
                else
                begin
                    stop = 1'b1;
                end
            end
        end
        return neg ? (8'd0 - acc) : acc;
    endfunction

    // Maps the two command letters to a status code.
    function automatic logic [3:0] lookup_cmd(input char_t c0, input char_t c1);
        logic [3:0] st;
        case ({c0, c1})
            "AT":    st = ST_SET_A;
            "BT":    st = ST_SET_B;
            "CT":    st = ST_SET_C;
            "DT":    st = ST_SET_D;
            "ET":    st = ST_SET_E;
            "OC":    st = ST_REPORT;
            "L1":    st = ST_LAMP_ON;
            "L0":    st = ST_LAMP_OFF;
            "CR":    st = ST_CLEAR;
            "DA":    st = ST_FULL;
            "HA":    st = ST_HALF;
            default: st = ST_WRONG;
        endcase
        return st;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/scl_line_buf.sv =====
// Line buffer of the serial command line decoder: stored characters and fill count.
// Presents the first line positions as they stand once the current character is stored.
// Depends on scl_pkg.
`default_nettype none

module scl_line_buf (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               write_en,
    input  wire scl_pkg::char_t     rx_char,
    input  wire logic               line_end,
    output scl_pkg::line_view_t     view
);
    import scl_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_after;
    char_t              line_reg [LINE_DEPTH];
    logic               has_room;

    // Characters beyond the depth are dropped.
    assign has_room    = (count_reg < COUNT_W'(LINE_DEPTH));
    assign count_after = has_room ? (count_reg + COUNT_W'(1)) : count_reg;

    // View of the leading positions with the current character merged in.
    always_comb
    begin
        for (int i = 0; i < VIEW_LEN; i++)
        begin
            view.chars[i]   = (has_room && (count_reg == COUNT_W'(i))) ? rx_char : line_reg[i];
            view.present[i] = (COUNT_W'(i) < count_after);
        end
    end

    // A line end returns the count to zero.
    always_comb
    begin
        count_next = count_reg;
        if (write_en)
        begin
            count_next = line_end ? '0 : count_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Character storage; each entry is written only at its own position.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LINE_DEPTH; i++)
        begin
            if (write_en && has_room && (count_reg == COUNT_W'(i)))
            begin
                line_reg[i] <= rx_char;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/scl_cmd_decode.sv =====
// Command decoder of the serial command line decoder: line end detection,
// command lookup and argument parsing for one character.
// Depends on scl_pkg.
`default_nettype none

module scl_cmd_decode (
    input  wire scl_pkg::char_t      rx_char,
    input  wire scl_pkg::line_view_t view,
    output scl_pkg::cmd_result_t     result
);
    import scl_pkg::*;

    logic       line_end;
    logic [3:0] cmd_status;

    assign line_end = (rx_char == CH_CR) || (rx_char == CH_LF);

    // A command needs both letters to be present in the line.
    assign cmd_status = view.present[1] ? lookup_cmd(view.chars[0], view.chars[1]) : ST_WRONG;

    always_comb
    begin
        result.line_done = line_end;
        result.accepted  = line_end && (cmd_status != ST_WRONG);
        result.status    = line_end ? cmd_status : ST_NONE;
        result.number    = parse_number(view);
    end

endmodule

`default_nettype wire

// ===== rtl/serial_command_line_decoder.sv =====
// Serial command line decoder, top level.
// Takes one received character per transfer on the s_ channel and returns one
// result per character on the m_ channel: the echoed character, the command
// status, and the duty, lamp and wave state after that character.
// A CR or LF character ends the line; its result carries m_tlast high and the
// status of the command spelled by the first two characters of the line.
// A character accepted on the s_ channel is registered at the input, then decoded
// and applied as it is written into the result register, which presents its result.
// Throughput: one character per cycle while the receiver takes results, set by the
// single decode-and-update pass between the input register and the result register.
// When the receiver stalls, the result register holds its transfer and the input
// register still takes one more character; s_tready drops only once both are full.
// Reset clears the line count, all duties, the lamp and the wave level, and
// empties both registers.
// Depends on scl_pkg, scl_line_buf and scl_cmd_decode.
`default_nettype none

module serial_command_line_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,  // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] echo_byte, [8] accepted, [12:9] status_code, [20:13] duty_a,
    // [28:21] duty_b, [36:29] duty_c, [44:37] duty_d, [52:45] duty_e,
    // [53] led_on, [61:54] wave_level, [63:62] wave_reload
    output logic [63:0]      m_tdata,
    output logic             m_tlast   // line_done
);
    import scl_pkg::*;

    logic        in_valid_reg;
    char_t       in_char_reg;
    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg;
    logic        m_tlast_reg;
    logic [63:0] out_word_next;
    logic        exec_ready;
    logic        process;

    char_t       duty_reg  [NUM_DUTY];
    char_t       duty_next [NUM_DUTY];
    logic        lamp_reg;
    logic        lamp_next;
    char_t       level_reg;
    char_t       level_next;
    logic [1:0]  reload_next;

    line_view_t  view;
    cmd_result_t cmd;

    // Handshake: the result register frees the update stage, which frees the input register.
    assign exec_ready = !m_tvalid_reg || m_tready;
    assign process    = in_valid_reg && exec_ready;
    assign s_tready   = !in_valid_reg || exec_ready;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_char_reg <= s_tdata;
        end
    end

    scl_line_buf u_line_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .write_en (process),
        .rx_char  (in_char_reg),
        .line_end (cmd.line_done),
        .view     (view)
    );

    scl_cmd_decode u_cmd_decode (
        .rx_char (in_char_reg),
        .view    (view),
        .result  (cmd)
    );

    // Command execution on the duty, lamp and wave state.
    always_comb
    begin
        for (int i = 0; i < NUM_DUTY; i++)
        begin
            duty_next[i] = duty_reg[i];
        end
        lamp_next   = lamp_reg;
        level_next  = level_reg;
        reload_next = RL_NONE;
        case (cmd.status)
            ST_SET_A:    duty_next[0] = cmd.number;
            ST_SET_B:    duty_next[1] = cmd.number;
            ST_SET_C:    duty_next[2] = cmd.number;
            ST_SET_D:    duty_next[3] = cmd.number;
            ST_SET_E:    duty_next[4] = cmd.number;
            ST_LAMP_ON:  lamp_next = 1'b1;
            ST_LAMP_OFF: lamp_next = 1'b0;
            ST_CLEAR:
            begin
                for (int i = 0; i < NUM_DUTY; i++)
                begin
                    duty_next[i] = '0;
                end
            end
            ST_FULL:
            begin
                level_next  = cmd.number;
                reload_next = RL_FULL;
            end
            ST_HALF:
            begin
                level_next  = cmd.number;
                reload_next = RL_HALF;
            end
            default:
            begin
                lamp_next = lamp_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DUTY; i++)
            begin
                duty_reg[i] <= '0;
            end
            lamp_reg  <= 1'b0;
            level_reg <= '0;
        end
        else if (process)
        begin
            for (int i = 0; i < NUM_DUTY; i++)
            begin
                duty_reg[i] <= duty_next[i];
            end
            lamp_reg  <= lamp_next;
            level_reg <= level_next;
        end
    end

    // Result word, highest field first.
    assign out_word_next = {reload_next, level_next, lamp_next,
                            duty_next[4], duty_next[3], duty_next[2], duty_next[1], duty_next[0],
                            cmd.status, cmd.accepted, in_char_reg};

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (exec_ready)
        begin
            m_tvalid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            m_tdata_reg <= out_word_next;
            m_tlast_reg <= cmd.line_done;
        end
    end

`ifndef ASSERT_OFF
    // Every ended line reports a status, and only ended lines do.
    a_status_on_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (m_tlast_reg == (m_tdata_reg[12:9] != ST_NONE)))
        else $error("status does not agree with line end");

    // An accepted command is always a line end with a known status.
    a_accept_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tdata_reg[8]) |-> (m_tlast_reg && m_tdata_reg[12:9] != ST_WRONG))
        else $error("accepted without a known command");

    // A wave request comes only with a full or half wave command.
    a_reload_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tdata_reg[63:62] != RL_NONE) |->
        (m_tdata_reg[12:9] == ST_FULL || m_tdata_reg[12:9] == ST_HALF))
        else $error("wave request without a wave command");

    // State moves only when a character is processed.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !process |=> ($stable(lamp_reg) && $stable(level_reg)))
        else $error("state changed without a processed character");
`endif

endmodule

`default_nettype wire
